// File: sv/mpef_pkg.sv
package mpef_pkg;

    localparam int COORD_BITS   = 10;
    localparam int ANGLE_BITS   = 16;
    localparam int LEN_BITS     = COORD_BITS + 1;
    localparam int CORDIC_STEPS = 28;
    localparam int PRE_SHIFT    = 30 - COORD_BITS;
    // x can grow past 2^31 by the CORDIC gain; keep headroom and a sign bit
    localparam int CW           = 34;
    localparam int ZW           = 34;
    localparam int SQ_BITS      = 2 * COORD_BITS + 2;

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [COORD_BITS:0] dx;
        logic [COORD_BITS:0] dy;
        t_angle              ref_dir;
        t_angle              nb_dir;
    } t_in_item;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            24: t = 32'd41;
            25: t = 32'd20;
            26: t = 32'd10;
            27: t = 32'd5;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// File: sv/mpef_in_if.sv
interface mpef_in_if
    import mpef_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord ref_x;
    t_coord ref_y;
    t_angle ref_dir;
    t_coord nb_x;
    t_coord nb_y;
    t_angle nb_dir;

    modport source (output valid, ref_x, ref_y, ref_dir, nb_x, nb_y, nb_dir, input ready);
    modport sink   (input valid, ref_x, ref_y, ref_dir, nb_x, nb_y, nb_dir, output ready);
endinterface

// File: sv/mpef_out_if.sv
interface mpef_out_if
    import mpef_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] edge_length;
    t_angle              ref_rel_angle;
    t_angle              nb_rel_angle;

    modport source (output valid, edge_length, ref_rel_angle, nb_rel_angle, input ready);
    modport sink   (input valid, edge_length, ref_rel_angle, nb_rel_angle, output ready);
endinterface

// File: sv/minutia_pair_edge_features.sv
// Edge features of a minutia pair.
// i_pair carries two minutiae (column, row, binary-angle direction); o_feat
// returns floor of their distance and each direction relative to the edge
// angle (reference toward neighbor, and its reverse). Both channels use
// valid/ready; a transfer happens when both are high.
// Pipeline: one stage of differences, one stage of absolute values and the
// squared distance, 28 CORDIC stages (one rotation each) with the integer
// square root running one result bit per stage beside them, then one stage
// that folds the quadrant and forms the angles. Throughput is one pair per
// cycle unless the output stalls; the CORDIC pipeline depth sets the latency.
// A stalled receiver freezes the whole pipeline in place (ready falls at the
// input once the output register is full and not taken); nothing is lost or
// repeated. Synchronous active-low reset clears all valid bits; the data
// registers are not reset.
module minutia_pair_edge_features
    import mpef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mpef_in_if.sink    i_pair,
    mpef_out_if.source o_feat
);

    localparam int NS = CORDIC_STEPS;   // CORDIC stages
    localparam int NR = LEN_BITS;       // root bits, done within first stages

    logic adv;
    assign adv          = !o_feat.valid || o_feat.ready;
    assign i_pair.ready = adv;

    // ---- stage 0: differences ----
    logic                   r_v0;
    logic [COORD_BITS:0]    r_dx, r_dy;
    t_angle                 r_rdir0, r_ndir0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_pair.valid;
        end
        if (adv) begin
            r_dx    <= {1'b0, i_pair.nb_x} - {1'b0, i_pair.ref_x};
            r_dy    <= {1'b0, i_pair.nb_y} - {1'b0, i_pair.ref_y};
            r_rdir0 <= i_pair.ref_dir;
            r_ndir0 <= i_pair.nb_dir;
        end
    end

    logic [COORD_BITS-1:0] ax0, ay0;
    assign ax0 = r_dx[COORD_BITS] ? COORD_BITS'(-r_dx) : r_dx[COORD_BITS-1:0];
    assign ay0 = r_dy[COORD_BITS] ? COORD_BITS'(-r_dy) : r_dy[COORD_BITS-1:0];

    logic [SQ_BITS-1:0] sq0;
    assign sq0 = SQ_BITS'(ax0) * SQ_BITS'(ax0) + SQ_BITS'(ay0) * SQ_BITS'(ay0);

    // ---- CORDIC + root pipeline: stage k holds results after k steps ----
    logic                   r_v   [NS+1];
    logic signed [CW-1:0]   r_x   [NS+1];
    logic signed [CW-1:0]   r_y   [NS+1];
    logic signed [ZW-1:0]   r_z   [NS+1];
    logic [1:0]             r_sgn [NS+1];   // {dx<0, dy<0}
    logic [1:0]             r_axz [NS+1];   // {ax==0, ay==0}
    t_angle                 r_rd  [NS+1];
    t_angle                 r_nd  [NS+1];
    logic [SQ_BITS-1:0]     r_rem [NS+1];
    logic [NR-1:0]          r_rt  [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= r_v0;
        end
        if (adv) begin
            r_x[0]   <= CW'({ax0, PRE_SHIFT'(0)});
            r_y[0]   <= CW'({ay0, PRE_SHIFT'(0)});
            r_z[0]   <= '0;
            r_sgn[0] <= {r_dx[COORD_BITS], r_dy[COORD_BITS]};
            r_axz[0] <= {ax0 == '0, ay0 == '0};
            r_rd[0]  <= r_rdir0;
            r_nd[0]  <= r_ndir0;
            r_rem[0] <= sq0;
            r_rt[0]  <= '0;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic signed [CW-1:0] sx, sy;
        logic [SQ_BITS-1:0]   rem_nx;
        logic [NR-1:0]        rt_nx;
        assign sx = r_x[k] >>> k;
        assign sy = r_y[k] >>> k;
        // root bit NR-1-k, restoring form; pass through once all bits are done
        if (k < NR) begin : g_rt
            localparam int B = NR - 1 - k;
            logic [SQ_BITS-1:0] trial;
            assign trial  = (SQ_BITS'(r_rt[k]) << (B + 1)) + (SQ_BITS'(1) << (2 * B));
            assign rem_nx = (r_rem[k] >= trial) ? r_rem[k] - trial : r_rem[k];
            assign rt_nx  = (r_rem[k] >= trial) ? (r_rt[k] | (NR'(1) << B)) : r_rt[k];
        end else begin : g_nort
            assign rem_nx = r_rem[k];
            assign rt_nx  = r_rt[k];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_v[k+1] <= r_v[k];
            end
            if (adv) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + sy;
                    r_y[k+1] <= r_y[k] - sx;
                    r_z[k+1] <= r_z[k] + ZW'(atan_turn(k));
                end else begin
                    r_x[k+1] <= r_x[k] - sy;
                    r_y[k+1] <= r_y[k] + sx;
                    r_z[k+1] <= r_z[k] - ZW'(atan_turn(k));
                end
                r_sgn[k+1] <= r_sgn[k];
                r_axz[k+1] <= r_axz[k];
                r_rd[k+1]  <= r_rd[k];
                r_nd[k+1]  <= r_nd[k];
                r_rem[k+1] <= rem_nx;
                r_rt[k+1]  <= rt_nx;
            end
        end
    end

    // ---- final stage: clamp, quadrant, round, relative angles ----
    logic [31:0] q, a;
    logic [32:0] ar;
    t_angle      e, r;
    always_comb begin
        if (r_z[NS] < 0)                           q = '0;
        else if (r_z[NS] > ZW'(QUARTER_TURN))     q = QUARTER_TURN;
        else                                       q = r_z[NS][31:0];
        if (r_axz[NS][0])       q = '0;
        else if (r_axz[NS][1])  q = QUARTER_TURN;
        case (r_sgn[NS])
            2'b00:   a = q;
            2'b10:   a = HALF_TURN - q;
            2'b11:   a = HALF_TURN + q;
            default: a = 32'd0 - q;
        endcase
        ar = {1'b0, a} + 33'(33'd1 << (31 - ANGLE_BITS));
        e  = ar[31 -: ANGLE_BITS];
        r  = e + t_angle'(t_angle'(1) << (ANGLE_BITS - 1));
        if (r_axz[NS] == 2'b11) begin
            e = '0;
            r = '0;
        end
    end

    logic                r_vo;
    logic [LEN_BITS-1:0] r_len;
    t_angle              r_ra, r_na;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= r_v[NS];
        end
        if (adv) begin
            r_len <= r_rt[NS];
            r_ra  <= r_rd[NS] - e;
            r_na  <= r_nd[NS] - r;
        end
    end

    assign o_feat.valid         = r_vo;
    assign o_feat.edge_length   = r_len;
    assign o_feat.ref_rel_angle = r_ra;
    assign o_feat.nb_rel_angle  = r_na;

`ifndef NO_ASSERTIONS
    // held output stays valid with a stable edge length under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_feat.valid && !o_feat.ready) |=> (o_feat.valid && $stable(o_feat.edge_length)))
        else $error("output changed while stalled");
    // coincident points give zero length and zero edge angle
    a_coinc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && adv && r_axz[NS] == 2'b11) |=>
        (r_len == '0 && r_ra == $past(r_rd[NS]) && r_na == $past(r_nd[NS])))
        else $error("coincident pair mishandled");
    // input ready follows output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_feat.valid) |-> i_pair.ready)
        else $error("ready low with empty output");
`endif

endmodule
